@@ rtl/fbl_pkg.sv @@
// shared constants, opcodes, state encoding and control/status bundles
// for the framebuffer fill and line engine; no dependencies
package fbl_pkg;

  localparam int FRAME_COLS_DEF = 128;
  localparam int FRAME_ROWS_DEF = 128;

  localparam int COORD_W   = 16;
  localparam int COLOR_W   = 32;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int DIV_W     = 16;

  localparam logic [7:0] ACTIVE_RESET = 8'd128;

  localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL  = 3'd3;
  localparam logic [OP_W-1:0] OP_LINE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_RECT  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_LINE  = 6'b010000,
    ST_RDOUT = 6'b100000
  } fbl_state_t;

  typedef struct packed {
    logic load;
    logic rect_init;
    logic rect_step;
    logic line_init;
    logic div_start;
    logic line_step;
    logic pix_write;
    logic pix_read;
    logic out_load;
  } fbl_ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            rect_empty;
    logic            rect_last;
    logic            line_empty;
    logic            line_last;
    logic            div_done;
    logic            out_free;
  } fbl_stat_t;

endpackage

@@ rtl/fbl_cmd_if.sv @@
// command channel: valid/ready with opcode, coordinates and color
// depends on fbl_pkg for field widths
interface fbl_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [fbl_pkg::OP_W-1:0]            opcode;
  logic signed [fbl_pkg::COORD_W-1:0]  x_first;
  logic signed [fbl_pkg::COORD_W-1:0]  y_first;
  logic signed [fbl_pkg::COORD_W-1:0]  x_second;
  logic signed [fbl_pkg::COORD_W-1:0]  y_second;
  logic [fbl_pkg::COLOR_W-1:0]         color;

  modport source (output valid, opcode, x_first, y_first, x_second, y_second, color,
                  input ready);
  modport sink (input valid, opcode, x_first, y_first, x_second, y_second, color,
                output ready);
endinterface

@@ rtl/fbl_pix_if.sv @@
// pixel read-back channel: valid/ready with the pixel value
// depends on fbl_pkg for the color width
interface fbl_pix_if;
  logic                        valid;
  logic                        ready;
  logic [fbl_pkg::COLOR_W-1:0] pixel_value;

  modport source (output valid, pixel_value, input ready);
  modport sink (input valid, pixel_value, output ready);
endinterface

@@ rtl/fbl_div.sv @@
// iterative restoring divider, one quotient bit per cycle
// depends on fbl_pkg for the operand width
module fbl_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fbl_pkg::DIV_W-1:0] dividend,
  input  logic [fbl_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [fbl_pkg::DIV_W-1:0] quotient,
  output logic [fbl_pkg::DIV_W-1:0] remainder
);
  localparam int N  = fbl_pkg::DIV_W;
  localparam int CW = $clog2(N);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [N-1:0]  quo;
  logic [N-1:0]  rem;
  logic [N-1:0]  dvs;
  logic [N:0]    trial;

  assign trial = {rem, quo[N-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[N]) begin
        rem <= trial[N-1:0];
        quo <= {quo[N-2:0], 1'b1};
      end else begin
        rem <= {rem[N-2:0], quo[N-1]};
        quo <= {quo[N-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

@@ rtl/fbl_dpath.sv @@
// datapath: command registers, config registers, rectangle and line walkers,
// frame store memory and result register; uses fbl_pkg and fbl_div
module fbl_dpath #(
  parameter int FRAME_COLS = fbl_pkg::FRAME_COLS_DEF,
  parameter int FRAME_ROWS = fbl_pkg::FRAME_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fbl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbl_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [fbl_pkg::OP_W-1:0]            opcode,
  input  logic signed [fbl_pkg::COORD_W-1:0]  x_first,
  input  logic signed [fbl_pkg::COORD_W-1:0]  y_first,
  input  logic signed [fbl_pkg::COORD_W-1:0]  x_second,
  input  logic signed [fbl_pkg::COORD_W-1:0]  y_second,
  input  logic [fbl_pkg::COLOR_W-1:0]         color,
  input  fbl_pkg::fbl_ctrl_t                  ctl,
  output fbl_pkg::fbl_stat_t                  stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [fbl_pkg::COLOR_W-1:0]         out_value
);
  localparam int DEPTH = FRAME_COLS * FRAME_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int W_SAT = (FRAME_COLS > 255) ? 255 : FRAME_COLS;
  localparam int H_SAT = (FRAME_ROWS > 255) ? 255 : FRAME_ROWS;

  // config
  logic [7:0] active_width;
  logic [7:0] active_height;
  logic [7:0] vis_w;
  logic [7:0] vis_h;

  // latched command
  logic [fbl_pkg::OP_W-1:0]     op;
  logic signed [15:0]           xa;
  logic signed [15:0]           ya;
  logic signed [15:0]           xb;
  logic signed [15:0]           yb;
  logic [fbl_pkg::COLOR_W-1:0]  col;

  // rectangle walker
  logic       fill_ok;
  logic [7:0] room_x;
  logic [7:0] room_y;
  logic [7:0] fill_w;
  logic [7:0] fill_h;
  logic [7:0] rxs;
  logic [7:0] rys;
  logic [7:0] rw;
  logic [7:0] rh;
  logic       rect_empty;
  logic [7:0] cx;
  logic [7:0] cy;
  logic [7:0] rx0;
  logic [7:0] xe;
  logic [7:0] ye;

  // line walker
  logic signed [16:0] dx17;
  logic signed [16:0] dy17;
  logic [15:0]        dy_mag;
  logic signed [15:0] lx;
  logic [15:0]        lq;
  logic [15:0]        lr;
  logic [15:0]        ldx;
  logic               lneg;
  logic signed [17:0] ly;
  logic signed [16:0] lx_next;
  logic [16:0]        r_sum;
  logic               r_carry;
  logic               line_inb;
  logic               div_done;
  logic [15:0]        qs;
  logic [15:0]        rs;

  // memory
  logic [fbl_pkg::COLOR_W-1:0] mem [DEPTH];
  logic [fbl_pkg::COLOR_W-1:0] rdata;
  logic [7:0]                  ax;
  logic [7:0]                  ay;
  logic [AW-1:0]               maddr;
  logic                        mem_we;
  logic                        mem_re;
  logic                        pix_inb;

  assign vis_w = (active_width > 8'(W_SAT)) ? 8'(W_SAT) : active_width;
  assign vis_h = (active_height > 8'(H_SAT)) ? 8'(H_SAT) : active_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= fbl_pkg::ACTIVE_RESET;
      active_height <= fbl_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fbl_pkg::CFG_WIDTH:  active_width  <= cfg_data;
        fbl_pkg::CFG_HEIGHT: active_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op  <= opcode;
      xa  <= x_first;
      ya  <= y_first;
      xb  <= x_second;
      yb  <= y_second;
      col <= color;
    end
  end

  assign pix_inb = !xa[15] && !ya[15] && (xa < $signed({8'b0, vis_w}))
                   && (ya < $signed({8'b0, vis_h}));

  // rectangle setup, clipped to right and bottom edges
  always_comb begin
    fill_ok = !xa[15] && !ya[15] && !xb[15] && !yb[15]
              && (xa < $signed({8'b0, vis_w})) && (ya < $signed({8'b0, vis_h}));
    room_x  = vis_w - xa[7:0];
    room_y  = vis_h - ya[7:0];
    fill_w  = (xb > $signed({8'b0, room_x})) ? room_x : xb[7:0];
    fill_h  = (yb > $signed({8'b0, room_y})) ? room_y : yb[7:0];
    if (op == fbl_pkg::OP_CLEAR) begin
      rxs        = 8'd0;
      rys        = 8'd0;
      rw         = vis_w;
      rh         = vis_h;
      rect_empty = (vis_w == 8'd0) || (vis_h == 8'd0);
    end else begin
      rxs        = xa[7:0];
      rys        = ya[7:0];
      rw         = fill_w;
      rh         = fill_h;
      rect_empty = !fill_ok || (fill_w == 8'd0) || (fill_h == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rect_init) begin
      cx  <= rxs;
      cy  <= rys;
      rx0 <= rxs;
      xe  <= rxs + rw;
      ye  <= rys + rh;
    end else if (ctl.rect_step) begin
      if (cx == xe - 8'd1) begin
        cx <= rx0;
        cy <= cy + 8'd1;
      end else begin
        cx <= cx + 8'd1;
      end
    end
  end

  // line setup: per-step quotient and remainder of |dy|/dx from the divider
  assign dx17   = {xb[15], xb} - {xa[15], xa};
  assign dy17   = {yb[15], yb} - {ya[15], ya};
  assign dy_mag = dy17[16] ? 16'(-dy17) : dy17[15:0];

  fbl_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (dy_mag),
    .divisor   (dx17[15:0]),
    .done      (div_done),
    .quotient  (qs),
    .remainder (rs)
  );

  assign ly      = lneg ? ({{2{ya[15]}}, ya} - $signed({2'b0, lq}))
                        : ({{2{ya[15]}}, ya} + $signed({2'b0, lq}));
  assign lx_next = {lx[15], lx} + 17'sd1;
  assign r_sum   = {1'b0, lr} + {1'b0, rs};
  assign r_carry = r_sum >= {1'b0, ldx};
  assign line_inb = !lx[15] && !ly[17] && (lx < $signed({8'b0, vis_w}))
                    && (ly < $signed({10'b0, vis_h}));

  always_ff @(posedge clk) begin
    if (ctl.line_init) begin
      lx   <= xa;
      lq   <= '0;
      lr   <= '0;
      ldx  <= dx17[15:0];
      lneg <= dy17[16];
    end else if (ctl.line_step) begin
      lx <= lx_next[15:0];
      lr <= r_carry ? 16'(r_sum - {1'b0, ldx}) : r_sum[15:0];
      lq <= lq + qs + {15'b0, r_carry};
    end
  end

  // memory port
  always_comb begin
    if (ctl.rect_step) begin
      ax = cx;
      ay = cy;
    end else if (ctl.line_step) begin
      ax = lx[7:0];
      ay = ly[7:0];
    end else begin
      ax = xa[7:0];
      ay = ya[7:0];
    end
  end

  assign maddr  = AW'(ay) * AW'(FRAME_COLS) + AW'(ax);
  assign mem_we = (ctl.pix_write && pix_inb) || ctl.rect_step || (ctl.line_step && line_inb);
  assign mem_re = ctl.pix_read && pix_inb;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[maddr] <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[maddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_value <= pix_inb ? rdata : '0;
    end
  end

  always_comb begin
    stat.op         = op;
    stat.rect_empty = rect_empty;
    stat.rect_last  = (cx == xe - 8'd1) && (cy == ye - 8'd1);
    stat.line_empty = dx17[16] || (dx17 == 17'sd0);
    stat.line_last  = (lx_next >= $signed({xb[15], xb}))
                      || (lx_next >= $signed({9'b0, vis_w}));
    stat.div_done   = div_done;
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

@@ rtl/fbl_ctrl.sv @@
// controller state machine sequencing commands over the datapath
// depends on fbl_pkg for states, opcodes and control/status bundles
module fbl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  fbl_pkg::fbl_stat_t stat,
  output fbl_pkg::fbl_ctrl_t ctl
);
  fbl_pkg::fbl_state_t state;
  fbl_pkg::fbl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_ready = (state == fbl_pkg::ST_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      fbl_pkg::ST_IDLE: begin
        ctl.load = cmd_valid;
        if (cmd_valid) begin
          state_next = fbl_pkg::ST_SETUP;
        end
      end
      fbl_pkg::ST_SETUP: begin
        case (stat.op)
          fbl_pkg::OP_CLEAR, fbl_pkg::OP_FILL: begin
            if (stat.rect_empty) begin
              state_next = fbl_pkg::ST_IDLE;
            end else begin
              ctl.rect_init = 1'b1;
              state_next    = fbl_pkg::ST_RECT;
            end
          end
          fbl_pkg::OP_WRITE: begin
            ctl.pix_write = 1'b1;
            state_next    = fbl_pkg::ST_IDLE;
          end
          fbl_pkg::OP_READ: begin
            ctl.pix_read = 1'b1;
            state_next   = fbl_pkg::ST_RDOUT;
          end
          fbl_pkg::OP_LINE: begin
            if (stat.line_empty) begin
              state_next = fbl_pkg::ST_IDLE;
            end else begin
              ctl.line_init = 1'b1;
              ctl.div_start = 1'b1;
              state_next    = fbl_pkg::ST_DIV;
            end
          end
          default: state_next = fbl_pkg::ST_IDLE;
        endcase
      end
      fbl_pkg::ST_RECT: begin
        ctl.rect_step = 1'b1;
        if (stat.rect_last) begin
          state_next = fbl_pkg::ST_IDLE;
        end
      end
      fbl_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_next = fbl_pkg::ST_LINE;
        end
      end
      fbl_pkg::ST_LINE: begin
        ctl.line_step = 1'b1;
        if (stat.line_last) begin
          state_next = fbl_pkg::ST_IDLE;
        end
      end
      fbl_pkg::ST_RDOUT: begin
        // hold the read data until the result register frees up
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = fbl_pkg::ST_IDLE;
        end
      end
      default: state_next = fbl_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/framebuffer_fill_and_line_engine_top.sv @@
// Drawing engine over a FRAME_COLS x FRAME_ROWS store of 32-bit pixels. One command
// is worked at a time; a command is taken the cycle after the previous one ends,
// even while a read result still waits in the output register. Clear and fill
// write one pixel per cycle. A pixel read has a registered memory read, then waits
// until the result register is free. A line first runs the slope divide (one
// quotient bit per cycle), then steps x by one until x reaches the end point or
// the right edge; steps left of the screen are still walked but write nothing.
// No clearing pass follows reset: the store is undefined until written.
// uses fbl_pkg, fbl_cmd_if, fbl_pix_if, fbl_ctrl and fbl_dpath
module framebuffer_fill_and_line_engine_top #(
  parameter int FRAME_COLS = fbl_pkg::FRAME_COLS_DEF,
  parameter int FRAME_ROWS = fbl_pkg::FRAME_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  fbl_cmd_if.sink                        cmd,
  fbl_pix_if.source                      pix,
  input  logic                           cfg_we,
  input  logic [fbl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbl_pkg::CFG_DATA_W-1:0] cfg_data
);
  fbl_pkg::fbl_ctrl_t ctl;
  fbl_pkg::fbl_stat_t stat;

  fbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  fbl_dpath #(
    .FRAME_COLS (FRAME_COLS),
    .FRAME_ROWS (FRAME_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (cmd.opcode),
    .x_first   (cmd.x_first),
    .y_first   (cmd.y_first),
    .x_second  (cmd.x_second),
    .y_second  (cmd.y_second),
    .color     (cmd.color),
    .ctl       (ctl),
    .stat      (stat),
    .out_ready (pix.ready),
    .out_valid (pix.valid),
    .out_value (pix.pixel_value)
  );

  // the line walk starts right after the slope divide finishes
  a_div_to_line: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |=> ctl.line_step)
    else $error("line walk did not follow divider completion");

  // a result only appears after the read state hands it over
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(pix.valid) |-> $past(ctl.out_load))
    else $error("result valid without a read transfer");

  // no command transfer while a walker is drawing
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |-> !(ctl.rect_step || ctl.line_step))
    else $error("command accepted while drawing");

endmodule

@@ tb/tb_framebuffer_fill_and_line_engine_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for framebuffer_fill_and_line_engine_top: draws commands
// through the command channel and checks every pixel read-back against a shadow store
// depends on fbl_pkg, fbl_cmd_if, fbl_pix_if and the engine top level
module tb_framebuffer_fill_and_line_engine_top;

  typedef logic [fbl_pkg::OP_W-1:0] opcode_t;

  localparam int MAX_W = fbl_pkg::FRAME_COLS_DEF;
  localparam int MAX_H = fbl_pkg::FRAME_ROWS_DEF;
  localparam opcode_t OP_TOP = '1;
  localparam int STALL_LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 212;

  typedef struct {
    opcode_t                            op;
    logic signed [fbl_pkg::COORD_W-1:0] xa;
    logic signed [fbl_pkg::COORD_W-1:0] ya;
    logic signed [fbl_pkg::COORD_W-1:0] xb;
    logic signed [fbl_pkg::COORD_W-1:0] yb;
    logic [fbl_pkg::COLOR_W-1:0]        color;
  } draw_cmd_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [fbl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fbl_pkg::CFG_DATA_W-1:0] cfg_data;

  fbl_cmd_if cmd_ch ();
  fbl_pix_if pix_ch ();

  framebuffer_fill_and_line_engine_top uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .pix       (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the engine
  logic [fbl_pkg::COLOR_W-1:0] frame_copy [MAX_W*MAX_H];
  logic [7:0] shadow_width;
  logic [7:0] shadow_height;

  draw_cmd_t pending_cmds [$];
  logic [fbl_pkg::COLOR_W-1:0] expected_pixels [$];
  draw_cmd_t cur_cmd;

  int mismatches;
  int src_gap;
  int sink_gap;
  int stall_cycles;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint view_w();
    return (shadow_width > MAX_W) ? MAX_W : longint'(shadow_width);
  endfunction

  function automatic longint view_h();
    return (shadow_height > MAX_H) ? MAX_H : longint'(shadow_height);
  endfunction

  function automatic bit in_view(longint x, longint y);
    return x >= 0 && y >= 0 && x < view_w() && y < view_h();
  endfunction

  function automatic void put_pixel(longint x, longint y, logic [fbl_pkg::COLOR_W-1:0] c);
    if (in_view(x, y))
      frame_copy[y*MAX_W + x] = c;
  endfunction

  // apply one transferred command to the shadow store
  function automatic void paint_command(draw_cmd_t c);
    longint vw, vh, xa, ya, xb, yb, rw, rh, dx, dy, px, py;
    vw = view_w();
    vh = view_h();
    xa = c.xa;
    ya = c.ya;
    xb = c.xb;
    yb = c.yb;
    case (c.op)
      fbl_pkg::OP_CLEAR: begin
        for (py = 0; py < vh; py++)
          for (px = 0; px < vw; px++)
            frame_copy[py*MAX_W + px] = c.color;
      end
      fbl_pkg::OP_WRITE: put_pixel(xa, ya, c.color);
      fbl_pkg::OP_READ: begin
        expected_pixels.push_back(in_view(xa, ya) ? frame_copy[ya*MAX_W + xa] : '0);
      end
      fbl_pkg::OP_FILL: begin
        rw = xb;
        rh = yb;
        if (!(xa < 0 || ya < 0 || xa >= vw || ya >= vh || rw < 0 || rh < 0)) begin
          if (xa + rw > vw) rw = vw - xa;
          if (ya + rh > vh) rh = vh - ya;
          for (py = ya; py < ya + rh; py++)
            for (px = xa; px < xa + rw; px++)
              frame_copy[py*MAX_W + px] = c.color;
        end
      end
      fbl_pkg::OP_LINE: begin
        dx = xb - xa;
        dy = yb - ya;
        if (dx > 0) begin
          for (px = xa; px < xb; px++) begin
            py = ya + (dy * (px - xa)) / dx;
            put_pixel(px, py, c.color);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [fbl_pkg::COLOR_W-1:0] got,
                                 logic [fbl_pkg::COLOR_W-1:0] want);
    $display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic enqueue_draw(opcode_t op, int xa, int ya, int xb, int yb,
                              logic [fbl_pkg::COLOR_W-1:0] color);
    draw_cmd_t c;
    c.op = op;
    c.xa = 16'(xa);
    c.ya = 16'(ya);
    c.xb = 16'(xb);
    c.yb = 16'(yb);
    c.color = color;
    pending_cmds.push_back(c);
  endtask

  // mostly on screen, sometimes just off an edge, sometimes anywhere
  function automatic logic signed [fbl_pkg::COORD_W-1:0] coord_near(longint lim);
    case ($urandom_range(0, 9))
      0: return 16'($urandom());
      1: return 16'(-int'($urandom_range(1, 4)));
      2: return 16'(lim + $urandom_range(0, 3));
      default: return (lim > 0) ? 16'($urandom_range(0, int'(lim) - 1))
                                : 16'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic draw_cmd_t random_draw();
    draw_cmd_t c;
    int k;
    k = $urandom_range(0, 99);
    c.color = $urandom();
    c.xa = coord_near(view_w());
    c.ya = coord_near(view_h());
    c.xb = 16'($urandom_range(0, 12));
    c.yb = 16'($urandom_range(0, 12));
    if (k < 3) begin
      c.op = opcode_t'($urandom_range(0, OP_TOP));
      c.xa = 16'($urandom());
      c.ya = 16'($urandom());
      c.xb = 16'($urandom());
      c.yb = 16'($urandom());
    end else if (k < 28) begin
      c.op = fbl_pkg::OP_WRITE;
    end else if (k < 58) begin
      c.op = fbl_pkg::OP_READ;
    end else if (k < 78) begin
      c.op = fbl_pkg::OP_FILL;
      case ($urandom_range(0, 19))
        0: c.xb = 16'(-int'($urandom_range(1, 3)));
        1: c.yb = 16'(-int'($urandom_range(1, 3)));
        2: begin
          c.xb = 16'($urandom_range(0, 200));
          c.yb = 16'($urandom_range(0, 200));
        end
        default: ;
      endcase
    end else if (k < 96) begin
      c.op = fbl_pkg::OP_LINE;
      c.xb = 16'(int'(c.xa) + int'($urandom_range(0, 44)) - 4);
      c.yb = 16'(int'(c.ya) + int'($urandom_range(0, 120)) - 60);
    end else if (k < 97) begin
      c.op = fbl_pkg::OP_CLEAR;
    end else begin
      c.op = opcode_t'($urandom_range(fbl_pkg::OP_LINE + 1, OP_TOP));
      c.xb = 16'($urandom());
      c.yb = 16'($urandom());
    end
    return c;
  endfunction

  task automatic write_register(logic [fbl_pkg::CFG_IDX_W-1:0] idx,
                                logic [fbl_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == fbl_pkg::CFG_WIDTH) shadow_width = value;
    else shadow_height = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a trailing read marks the point where all earlier commands have finished
  task automatic drain_engine();
    enqueue_draw(fbl_pkg::OP_READ, 0, 0, 0, 0, '0);
    while (pending_cmds.size() != 0 || cmd_ch.valid || expected_pixels.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (8) @(posedge clk);
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        paint_command(cur_cmd);
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          cmd_ch.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.opcode <= cur_cmd.op;
          cmd_ch.x_first <= cur_cmd.xa;
          cmd_ch.y_first <= cur_cmd.ya;
          cmd_ch.x_second <= cur_cmd.xb;
          cmd_ch.y_second <= cur_cmd.yb;
          cmd_ch.color <= cur_cmd.color;
          if (idle_on && $urandom_range(0, 7) == 0)
            src_gap = $urandom_range(1, 14);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // read-back monitor
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        if (expected_pixels.size() == 0)
          report_mismatch("unexpected pixel_value", pix_ch.pixel_value, '0);
        else if (pix_ch.pixel_value !== expected_pixels[0])
          report_mismatch("pixel_value", pix_ch.pixel_value, expected_pixels.pop_front());
        else
          void'(expected_pixels.pop_front());
      end
      if (sink_gap > 0) begin
        sink_gap--;
        pix_ch.ready <= 1'b0;
      end else begin
        pix_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 11) == 0)
          sink_gap = $urandom_range(1, 14);
      end
    end
  end

  // no transfer for too long while work is outstanding
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
        (pending_cmds.size() == 0 && !cmd_ch.valid && expected_pixels.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int phase_w [PHASES];
    int phase_h [PHASES];
    int n;
    draw_cmd_t c;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = fbl_pkg::CFG_WIDTH;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = fbl_pkg::OP_CLEAR;
    cmd_ch.x_first = '0;
    cmd_ch.y_first = '0;
    cmd_ch.x_second = '0;
    cmd_ch.y_second = '0;
    cmd_ch.color = '0;
    pix_ch.ready = 1'b0;
    shadow_width = fbl_pkg::ACTIVE_RESET;
    shadow_height = fbl_pkg::ACTIVE_RESET;
    mismatches = 0;
    idle_on = 1'b1;
    phase_w = '{128, 1, 255, 0, 128, 1, 1, 1};
    phase_h = '{128, 1, 255, 0, 1, 128, 1, 1};
    phase_w[6] = $urandom_range(1, 128);
    phase_h[6] = $urandom_range(1, 128);
    phase_w[7] = $urandom_range(1, 128);
    phase_h[7] = $urandom_range(1, 128);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_register(fbl_pkg::CFG_WIDTH, 8'd128);
    write_register(fbl_pkg::CFG_HEIGHT, 8'd128);

    // full clear first so that every later on-screen read hits a written pixel
    enqueue_draw(fbl_pkg::OP_CLEAR, 0, 0, 0, 0, 32'hA5A5_5A5A);
    enqueue_draw(fbl_pkg::OP_WRITE, 0, 0, 0, 0, 32'hFFFF_FFFF);
    enqueue_draw(fbl_pkg::OP_WRITE, 127, 127, 0, 0, 32'h0000_0001);
    enqueue_draw(fbl_pkg::OP_WRITE, 127, 0, 0, 0, 32'h8000_0000);
    enqueue_draw(fbl_pkg::OP_WRITE, -1, 5, 0, 0, 32'h1234_5678);
    enqueue_draw(fbl_pkg::OP_WRITE, 128, 5, 0, 0, 32'h1234_5678);
    enqueue_draw(fbl_pkg::OP_WRITE, -32768, 32767, 0, 0, 32'h1234_5678);
    enqueue_draw(fbl_pkg::OP_READ, 0, 0, 0, 0, '0);
    enqueue_draw(fbl_pkg::OP_READ, 127, 127, 0, 0, '0);
    enqueue_draw(fbl_pkg::OP_READ, 127, 0, 0, 0, '0);
    enqueue_draw(fbl_pkg::OP_READ, -1, 5, 0, 0, '0);
    enqueue_draw(fbl_pkg::OP_READ, 32767, -32768, 0, 0, '0);
    enqueue_draw(fbl_pkg::OP_FILL, 10, 20, 5, 3, 32'h00C0_FFEE);
    enqueue_draw(fbl_pkg::OP_FILL, -1, 0, 4, 4, 32'h0BAD_0001);
    enqueue_draw(fbl_pkg::OP_FILL, 0, 0, -1, 3, 32'h0BAD_0002);
    enqueue_draw(fbl_pkg::OP_FILL, 128, 0, 2, 2, 32'h0BAD_0003);
    enqueue_draw(fbl_pkg::OP_FILL, 120, 125, 32767, 32767, 32'h5555_AAAA);
    enqueue_draw(fbl_pkg::OP_READ, 127, 127, 0, 0, '0);
    enqueue_draw(fbl_pkg::OP_READ, 12, 21, 0, 0, '0);
    enqueue_draw(fbl_pkg::OP_LINE, 0, 0, 20, 10, 32'h0F0F_F0F0);
    enqueue_draw(fbl_pkg::OP_LINE, 5, 50, 30, -10, 32'h7777_8888);
    enqueue_draw(fbl_pkg::OP_LINE, 30, 3, 30, 40, 32'h0BAD_0004);
    enqueue_draw(fbl_pkg::OP_LINE, 40, 3, 10, 3, 32'h0BAD_0005);
    enqueue_draw(fbl_pkg::OP_LINE, -32768, -32768, 32767, 32767, 32'h3C3C_C3C3);
    enqueue_draw(fbl_pkg::OP_LINE, -5, 7, 6, 2, 32'h2468_ACE0);
    enqueue_draw(fbl_pkg::OP_READ, 10, 5, 0, 0, '0);
    enqueue_draw(fbl_pkg::OP_READ, 2, 5, 0, 0, '0);
    enqueue_draw(opcode_t'(fbl_pkg::OP_LINE + 1), 3, 3, 9, 9, 32'hDEAD_0005);
    enqueue_draw(opcode_t'(fbl_pkg::OP_LINE + 2), 3, 3, 9, 9, 32'hDEAD_0006);
    enqueue_draw(OP_TOP, 3, 3, 9, 9, 32'hDEAD_0007);
    drain_engine();

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1);
      write_register(fbl_pkg::CFG_WIDTH, 8'(phase_w[p]));
      write_register(fbl_pkg::CFG_HEIGHT, 8'(phase_h[p]));
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        c = random_draw();
        pending_cmds.push_back(c);
        if (c.op <= fbl_pkg::OP_LINE) n++;
      end
      drain_engine();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fbl_pkg.sv
rtl/fbl_cmd_if.sv
rtl/fbl_pix_if.sv
rtl/fbl_div.sv
rtl/fbl_dpath.sv
rtl/fbl_ctrl.sv
rtl/framebuffer_fill_and_line_engine_top.sv
tb/tb_framebuffer_fill_and_line_engine_top.sv
